// ===== design/eisc_pkg.sv =====
// eisc_pkg: shared types, register offsets and sense codes for the
// external interrupt sense controller; used by the top level and its checker
package eisc_pkg;

  // channel counts
  localparam int PIN_CHANNELS  = 8;
  localparam int GPIO_CHANNELS = 32;
  localparam int GPIO_SOURCES  = 128;

  // register file shape
  localparam int SEL_WORDS    = 8;
  localparam int GSENSE_WORDS = 2;
  localparam int SRC_W        = 7;

  // item commands
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  // pin sense codes, two bits per pin
  typedef enum logic [1:0] {
    PS_LEVEL_LOW = 2'd0,
    PS_FALLING   = 2'd1,
    PS_RISING    = 2'd2,
    PS_BOTH      = 2'd3
  } psense_t;

  // gpio sense codes, two bits per channel
  typedef enum logic [1:0] {
    GS_RISING     = 2'd0,
    GS_FALLING    = 2'd1,
    GS_LEVEL_HIGH = 2'd2,
    GS_LEVEL_LOW  = 2'd3
  } gsense_t;

  // register byte offsets
  localparam logic [16:0] OFS_PSTAT   = 17'h00010;
  localparam logic [16:0] OFS_PSENSE  = 17'h00014;
  localparam logic [16:0] OFS_GSTAT   = 17'h00020;
  localparam logic [16:0] OFS_GSENSE0 = 17'h00024;
  localparam logic [16:0] OFS_GSENSE1 = 17'h00028;
  localparam logic [16:0] OFS_SEL0    = 17'h00030;
  localparam logic [16:0] OFS_SEL7    = 17'h0004C;
  localparam logic [16:0] OFS_PMASK   = 17'h10010;
  localparam logic [16:0] OFS_GMASK   = 17'h10020;

  typedef struct packed {
    logic [1:0]  command;
    logic [16:0] reg_offset;
    logic [31:0] write_data;
    logic [7:0]  pin_levels;
    logic [63:0] gpio_levels_low;
    logic [63:0] gpio_levels_high;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  pin_irq_out;
    logic [31:0] gpio_irq_out;
  } out_item_t;

endpackage

// ===== design/external_interrupt_sense_controller_top.sv =====
// external_interrupt_sense_controller_top: complete sense controller, register
// file, edge/level detection and output stage; depends on eisc_pkg
module external_interrupt_sense_controller_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  eisc_pkg::in_item_t  in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output eisc_pkg::out_item_t out_item
);
  // Eight pin interrupts and thirty-two gpio interrupts, each gpio channel
  // picking one of 128 level sources through its source-select byte. Every
  // item is a sample tick, a register read or a register write, and yields
  // exactly one result item carrying the read data (zero unless a read) and
  // both interrupt vectors (status and not mask) as they stand after the
  // item. Throughput is one item per clock unless in_stall holds the input;
  // the input and result registers bracket the single combinational pass over
  // the register file. The result register lets a new item enter while a
  // finished one waits on out_stall. Control and state registers come out of
  // reset at zero, payload ones do not: pins level-low sensed, gpio rising-edge
  // sensed, gpio channels disabled, nothing masked. No clearing pass.

  import eisc_pkg::*;

  // pipeline control
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  logic      advance;

  // architectural state
  logic [PIN_CHANNELS-1:0]               pin_status_r, pin_status_nxt;
  logic [2*PIN_CHANNELS-1:0]             pin_sense_r, pin_sense_nxt;
  logic [PIN_CHANNELS-1:0]               pin_mask_r, pin_mask_nxt;
  logic [PIN_CHANNELS-1:0]               prev_pin_r, prev_pin_nxt;
  logic [GPIO_CHANNELS-1:0]              gpio_status_r, gpio_status_nxt;
  logic [GPIO_CHANNELS-1:0]              gpio_mask_r, gpio_mask_nxt;
  logic [GPIO_CHANNELS-1:0]              prev_gpio_r, prev_gpio_nxt;
  logic [GSENSE_WORDS-1:0][31:0]         gsense_r, gsense_nxt;
  logic [SEL_WORDS-1:0][31:0]            sel_r, sel_nxt;

  // decode helpers
  logic [16:0]              ofs;
  logic [16:0]              sel_diff;
  logic [2:0]               sel_idx;
  logic [31:0]              pin_ext;
  logic [PIN_CHANNELS-1:0]  pins_cur;
  logic [127:0]             src_levels;
  logic [GPIO_CHANNELS-1:0] gpio_now;
  logic [GPIO_CHANNELS-1:0] gpio_en;
  logic [31:0]              rd;
  logic [31:0]              pin_irq_ext;

  // the item in the input register moves on unless a finished result is stuck
  assign advance   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // word aligned offset and source-select word index
  assign ofs      = {s1_item_r.reg_offset[16:2], 2'b00};
  assign sel_diff = ofs - OFS_SEL0;
  assign sel_idx  = sel_diff[4:2];

  // pins above the eight wired ones read low
  assign pin_ext  = 32'(s1_item_r.pin_levels);
  assign pins_cur = pin_ext[PIN_CHANNELS-1:0];

  assign src_levels = {s1_item_r.gpio_levels_high, s1_item_r.gpio_levels_low};

  // per channel source mux; sources beyond the populated range read low
  always_comb begin
    for (int i = 0; i < GPIO_CHANNELS; i++) begin
      gpio_en[i]  = sel_r[i/4][8*(i%4)+7];
      gpio_now[i] = ({1'b0, sel_r[i/4][8*(i%4) +: SRC_W]} < 8'(GPIO_SOURCES)) &&
                    src_levels[sel_r[i/4][8*(i%4) +: SRC_W]];
    end
  end

  // one pass: tick, read or write
  always_comb begin
    pin_status_nxt  = pin_status_r;
    pin_sense_nxt   = pin_sense_r;
    pin_mask_nxt    = pin_mask_r;
    prev_pin_nxt    = prev_pin_r;
    gpio_status_nxt = gpio_status_r;
    gpio_mask_nxt   = gpio_mask_r;
    prev_gpio_nxt   = prev_gpio_r;
    gsense_nxt      = gsense_r;
    sel_nxt         = sel_r;
    rd              = '0;

    case (s1_item_r.command)
      CMD_TICK: begin
        // pin detection against the previous sample
        for (int i = 0; i < PIN_CHANNELS; i++) begin
          case (pin_sense_r[2*i +: 2])
            PS_LEVEL_LOW: pin_status_nxt[i] = !pins_cur[i];
            PS_FALLING: begin
              if (prev_pin_r[i] && !pins_cur[i]) pin_status_nxt[i] = 1'b1;
            end
            PS_RISING: begin
              if (!prev_pin_r[i] && pins_cur[i]) pin_status_nxt[i] = 1'b1;
            end
            default: begin
              if (prev_pin_r[i] != pins_cur[i]) pin_status_nxt[i] = 1'b1;
            end
          endcase
        end
        prev_pin_nxt = pins_cur;

        // gpio detection; disabled channels keep status, sample still tracks
        for (int i = 0; i < GPIO_CHANNELS; i++) begin
          if (gpio_en[i]) begin
            case (gsense_r[i/16][2*(i%16) +: 2])
              GS_RISING: begin
                if (!prev_gpio_r[i] && gpio_now[i]) gpio_status_nxt[i] = 1'b1;
              end
              GS_FALLING: begin
                if (prev_gpio_r[i] && !gpio_now[i]) gpio_status_nxt[i] = 1'b1;
              end
              GS_LEVEL_HIGH: gpio_status_nxt[i] = gpio_now[i];
              default:       gpio_status_nxt[i] = !gpio_now[i];
            endcase
          end
        end
        prev_gpio_nxt = gpio_now;
      end

      CMD_READ: begin
        case (ofs) inside
          OFS_PSTAT:           rd = 32'(pin_status_r);
          OFS_PSENSE:          rd = 32'(pin_sense_r);
          OFS_GSTAT:           rd = 32'(gpio_status_r);
          OFS_GSENSE0:         rd = gsense_r[0];
          OFS_GSENSE1:         rd = gsense_r[1];
          [OFS_SEL0:OFS_SEL7]: rd = sel_r[sel_idx];
          OFS_PMASK:           rd = 32'(pin_mask_r);
          OFS_GMASK:           rd = 32'(gpio_mask_r);
          default:             rd = '0;
        endcase
      end

      CMD_WRITE: begin
        case (ofs) inside
          OFS_PSTAT: begin
            // write-zero clears, and only for pins in an edge mode
            for (int i = 0; i < PIN_CHANNELS; i++) begin
              if ((pin_sense_r[2*i +: 2] != PS_LEVEL_LOW) && !s1_item_r.write_data[i])
                pin_status_nxt[i] = 1'b0;
            end
          end
          OFS_PSENSE:  pin_sense_nxt = s1_item_r.write_data[2*PIN_CHANNELS-1:0];
          OFS_GSTAT:   gpio_status_nxt = gpio_status_r &
                                         s1_item_r.write_data[GPIO_CHANNELS-1:0];
          OFS_GSENSE0: gsense_nxt[0] = s1_item_r.write_data;
          OFS_GSENSE1: gsense_nxt[1] = s1_item_r.write_data;
          [OFS_SEL0:OFS_SEL7]: sel_nxt[sel_idx] = s1_item_r.write_data;
          OFS_PMASK:   pin_mask_nxt = s1_item_r.write_data[PIN_CHANNELS-1:0];
          OFS_GMASK:   gpio_mask_nxt = s1_item_r.write_data[GPIO_CHANNELS-1:0];
          default: ;
        endcase
      end

      default: ;
    endcase
  end

  // result reflects state after the item has acted
  assign pin_irq_ext = 32'(pin_status_nxt & ~pin_mask_nxt);

  always_comb begin
    out_item_nxt.read_data    = rd;
    out_item_nxt.pin_irq_out  = pin_irq_ext[7:0];
    out_item_nxt.gpio_irq_out = 32'(gpio_status_nxt & ~gpio_mask_nxt);
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      pin_status_r  <= '0;
      pin_sense_r   <= '0;
      pin_mask_r    <= '0;
      prev_pin_r    <= '0;
      gpio_status_r <= '0;
      gpio_mask_r   <= '0;
      prev_gpio_r   <= '0;
      gsense_r      <= '0;
      sel_r         <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        pin_status_r  <= pin_status_nxt;
        pin_sense_r   <= pin_sense_nxt;
        pin_mask_r    <= pin_mask_nxt;
        prev_pin_r    <= prev_pin_nxt;
        gpio_status_r <= gpio_status_nxt;
        gpio_mask_r   <= gpio_mask_nxt;
        prev_gpio_r   <= prev_gpio_nxt;
        gsense_r      <= gsense_nxt;
        sel_r         <= sel_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// ===== design/eisc_checker.sv =====
// eisc_checker: port-level assertions for the sense controller top level,
// bound to it below; depends on eisc_pkg
module eisc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input eisc_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input eisc_pkg::out_item_t out_item
);
  import eisc_pkg::*;

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("result item changed while stalled");

  // input side only stalls when a finished result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a fresh result comes from an accepted item via the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result item without an accepted input item");

endmodule

bind external_interrupt_sense_controller_top eisc_checker u_eisc_checker (.*);
